[src/twc_pkg.sv]
package twc_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 10;
    localparam int DEC_W  = 16;
    localparam int IDX_W  = 10;
    localparam int CH_W   = 2;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int REG_W  = 3;

    // operations
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd3;

    // engine states
    localparam logic [ST_W-1:0] ST_FREE = 2'd0;
    localparam logic [ST_W-1:0] ST_WAIT = 2'd1;
    localparam logic [ST_W-1:0] ST_FILL = 2'd2;
    localparam logic [ST_W-1:0] ST_STOP = 2'd3;

    // configuration register indexes
    localparam logic [REG_W-1:0] REG_LEVEL      = 3'd0;
    localparam logic [REG_W-1:0] REG_CHANNEL    = 3'd1;
    localparam logic [REG_W-1:0] REG_POSITION   = 3'd2;
    localparam logic [REG_W-1:0] REG_EDGE       = 3'd3;
    localparam logic [REG_W-1:0] REG_AUTO       = 3'd4;
    localparam logic [REG_W-1:0] REG_DECIMATION = 3'd5;
    localparam logic [REG_W-1:0] REG_TIMEOUT    = 3'd6;

    localparam logic [DATA_W-1:0] TIMEOUT_RESET = 32'd65536;

endpackage

[src/twc_if.sv]
interface twc_item_if;
    logic                             valid;
    logic                             ready;
    logic [twc_pkg::OP_W-1:0]         operation;
    logic signed [twc_pkg::DATA_W-1:0] sample_0;
    logic signed [twc_pkg::DATA_W-1:0] sample_1;
    logic signed [twc_pkg::DATA_W-1:0] sample_2;
    logic signed [twc_pkg::DATA_W-1:0] sample_3;
    logic [twc_pkg::CH_W-1:0]         read_channel;
    logic [twc_pkg::IDX_W-1:0]        read_index;

    modport source (output valid, operation, sample_0, sample_1, sample_2, sample_3,
                    read_channel, read_index, input ready);
    modport sink (input valid, operation, sample_0, sample_1, sample_2, sample_3,
                  read_channel, read_index, output ready);
endinterface

interface twc_result_if;
    logic                             valid;
    logic                             ready;
    logic [twc_pkg::ST_W-1:0]         capture_state;
    logic                             read_valid;
    logic signed [twc_pkg::DATA_W-1:0] read_data;
    logic                             error;

    modport source (output valid, capture_state, read_valid, read_data, error, input ready);
    modport sink (input valid, capture_state, read_valid, read_data, error, output ready);
endinterface

interface twc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [twc_pkg::REG_W-1:0]   index;
    logic [twc_pkg::DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/triggered_wave_capture_core.sv]
// pipeline: two register stages; an accepted transaction is registered in s1, then moves
// on to the output register once that register is free, where its result is presented
// throughput: one transaction per cycle, sample ticks and reads alike; a held result
// stalls the input once the stage behind it is also full
// reset: asynchronous, clears control state; the banks are not swept, a fill
// cursor and a wrap flag make never-written entries read as zero
module triggered_wave_capture_core #(
    parameter int BUFFER_DEPTH = 1024,
    parameter int CHANNELS     = 4,
    parameter int SAMPLE_WIDTH = 32
) (
    input logic         clk,
    input logic         rst_n,
    twc_item_if.sink    item,
    twc_result_if.source result,
    twc_cfg_if.sink     cfg
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int OW = ((AW > twc_pkg::POS_W) ? AW : twc_pkg::POS_W) + 2;
    localparam int POS_LO = -(BUFFER_DEPTH / 2) + 1;
    localparam int POS_HI = ((BUFFER_DEPTH + 1) / 2) - 1;
    localparam logic signed [OW-1:0] HALF_DEPTH = OW'(BUFFER_DEPTH / 2);

    typedef struct packed {
        logic [twc_pkg::ST_W-1:0] state;
        logic                     rd_ok;
        logic                     blank;
        logic                     err;
        logic [twc_pkg::CH_W-1:0] ch;
    } s1_t;

    // configuration registers
    logic signed [twc_pkg::DATA_W-1:0] level_reg;
    logic [twc_pkg::CH_W-1:0]          trig_ch_reg;
    logic signed [twc_pkg::POS_W-1:0]  pos_reg;
    logic                              falling_reg;
    logic                              auto_reg;
    logic [twc_pkg::DEC_W-1:0]         decim_reg;
    logic [twc_pkg::DATA_W-1:0]        timeout_reg;

    // engine state
    logic [twc_pkg::ST_W-1:0]   state_reg, state_next;
    logic [AW-1:0]              wc_reg, wc_next;
    logic                       wrapped_reg, wrapped_next;
    logic [AW-1:0]              end_reg, end_next;
    logic [twc_pkg::DEC_W-1:0]  dec_cnt_reg, dec_cnt_next;
    logic [twc_pkg::DATA_W-1:0] wait_reg, wait_next;
    logic                       kept_any_reg, kept_any_next;
    logic [3:0][twc_pkg::DATA_W-1:0] last_reg, last_next;

    // pipeline
    logic s1_valid_reg;
    s1_t  s1_reg, s1_next;
    logic                              out_valid_reg;
    logic [twc_pkg::ST_W-1:0]          out_state_reg;
    logic                              out_rd_ok_reg;
    logic signed [twc_pkg::DATA_W-1:0] out_data_reg;
    logic                              out_err_reg;
    logic                              s1_adv;
    logic                              in_acc;

    // datapath
    logic [3:0][twc_pkg::DATA_W-1:0] fit;
    logic [SAMPLE_WIDTH-1:0] bank_wdata [CHANNELS];
    logic [SAMPLE_WIDTH-1:0] bank_rdata [CHANNELS];
    logic                    mem_we;
    logic                    mem_re;
    logic [AW-1:0]           rd_addr;
    logic [SAMPLE_WIDTH-1:0] bank_word;
    logic signed [twc_pkg::DATA_W-1:0] rd_word;

    function automatic logic [twc_pkg::DATA_W-1:0] fit_sample(
        input logic [twc_pkg::DATA_W-1:0] raw
    );
        logic signed [SAMPLE_WIDTH-1:0] t;
        t = raw[SAMPLE_WIDTH-1:0];
        return twc_pkg::DATA_W'(t);
    endfunction

    assign fit[0] = fit_sample(item.sample_0);
    assign fit[1] = fit_sample(item.sample_1);
    assign fit[2] = fit_sample(item.sample_2);
    assign fit[3] = fit_sample(item.sample_3);

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_adv;
    assign in_acc     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= '0;
            trig_ch_reg <= '0;
            pos_reg     <= '0;
            falling_reg <= 1'b0;
            auto_reg    <= 1'b0;
            decim_reg   <= twc_pkg::DEC_W'(1);
            timeout_reg <= twc_pkg::TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                twc_pkg::REG_LEVEL:
                begin
                    level_reg <= cfg.data;
                end
                twc_pkg::REG_CHANNEL:
                begin
                    if (4'(cfg.data[twc_pkg::CH_W-1:0]) < 4'(CHANNELS))
                    begin
                        trig_ch_reg <= cfg.data[twc_pkg::CH_W-1:0];
                    end
                end
                twc_pkg::REG_POSITION:
                begin
                    if ($signed(cfg.data[twc_pkg::POS_W-1:0]) >= POS_LO &&
                        $signed(cfg.data[twc_pkg::POS_W-1:0]) <= POS_HI)
                    begin
                        pos_reg <= cfg.data[twc_pkg::POS_W-1:0];
                    end
                end
                twc_pkg::REG_EDGE:
                begin
                    falling_reg <= cfg.data[0];
                end
                twc_pkg::REG_AUTO:
                begin
                    auto_reg <= cfg.data[0];
                end
                twc_pkg::REG_DECIMATION:
                begin
                    if (cfg.data[twc_pkg::DEC_W-1:0] != '0)
                    begin
                        decim_reg <= cfg.data[twc_pkg::DEC_W-1:0];
                    end
                end
                twc_pkg::REG_TIMEOUT:
                begin
                    timeout_reg <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // engine update in the accept cycle
    always_comb
    begin
        logic [twc_pkg::DEC_W-1:0]  dec_inc;
        logic                       kept;
        logic [twc_pkg::DATA_W-1:0] now_v;
        logic [twc_pkg::DATA_W-1:0] before_v;
        logic                       now_above;
        logic                       before_above;
        logic                       edge_hit;
        logic                       timed;
        logic signed [OW-1:0]       off;
        logic [AW:0]                end_sum;
        logic [OW-1:0]              pos_sum;

        state_next    = state_reg;
        wc_next       = wc_reg;
        wrapped_next  = wrapped_reg;
        end_next      = end_reg;
        dec_cnt_next  = dec_cnt_reg;
        wait_next     = wait_reg;
        kept_any_next = kept_any_reg;
        last_next     = last_reg;
        s1_next       = '0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;

        dec_inc = dec_cnt_reg + twc_pkg::DEC_W'(1);
        if (dec_inc >= decim_reg)
        begin
            dec_inc = '0;
        end
        kept = (dec_inc == '0);

        now_v = fit[trig_ch_reg];
        // very first kept tick compares the trigger sample with itself
        before_v     = kept_any_reg ? last_reg[trig_ch_reg] : now_v;
        now_above    = $signed(now_v) > level_reg;
        before_above = $signed(before_v) > level_reg;
        edge_hit     = falling_reg ? (before_above && !now_above)
                                   : (!before_above && now_above);
        timed        = auto_reg && (wait_reg >= timeout_reg);

        off     = HALF_DEPTH - OW'(pos_reg);
        end_sum = (AW + 1)'(wc_reg) + (AW + 1)'(off[AW-1:0]);
        if (end_sum >= (AW + 1)'(BUFFER_DEPTH))
        begin
            end_sum = end_sum - (AW + 1)'(BUFFER_DEPTH);
        end

        // oldest entry sits right after the end point
        pos_sum = OW'(end_reg) + OW'(1) + OW'(item.read_index);
        if (pos_sum >= OW'(BUFFER_DEPTH))
        begin
            pos_sum = pos_sum - OW'(BUFFER_DEPTH);
        end
        rd_addr = pos_sum[AW-1:0];

        if (in_acc)
        begin
            case (item.operation)
                twc_pkg::OP_TICK:
                begin
                    if (state_reg != twc_pkg::ST_STOP)
                    begin
                        dec_cnt_next = dec_inc;
                        if (kept)
                        begin
                            mem_we = 1'b1;
                            if (state_reg == twc_pkg::ST_WAIT)
                            begin
                                if (edge_hit || timed)
                                begin
                                    end_next   = end_sum[AW-1:0];
                                    wait_next  = '0;
                                    state_next = twc_pkg::ST_FILL;
                                end
                                else if (auto_reg && wait_reg != '1)
                                begin
                                    wait_next = wait_reg + twc_pkg::DATA_W'(1);
                                end
                            end
                            else if (state_reg == twc_pkg::ST_FILL && wc_reg == end_reg)
                            begin
                                state_next = twc_pkg::ST_STOP;
                            end
                            last_next     = fit;
                            kept_any_next = 1'b1;
                            if (wc_reg == AW'(BUFFER_DEPTH - 1))
                            begin
                                wc_next      = '0;
                                wrapped_next = 1'b1;
                            end
                            else
                            begin
                                wc_next = wc_reg + AW'(1);
                            end
                        end
                    end
                end
                twc_pkg::OP_START:
                begin
                    state_next = twc_pkg::ST_WAIT;
                end
                twc_pkg::OP_READ:
                begin
                    if (state_reg != twc_pkg::ST_STOP)
                    begin
                        s1_next.err = 1'b1;
                    end
                    else if (4'(item.read_channel) < 4'(CHANNELS) &&
                             OW'(item.read_index) < OW'(BUFFER_DEPTH))
                    begin
                        mem_re        = 1'b1;
                        s1_next.rd_ok = 1'b1;
                        s1_next.blank = !(wrapped_reg || rd_addr < wc_reg);
                        s1_next.ch    = item.read_channel;
                    end
                end
                twc_pkg::OP_FINISH:
                begin
                    if (state_reg != twc_pkg::ST_STOP)
                    begin
                        s1_next.err = 1'b1;
                    end
                    else
                    begin
                        state_next = twc_pkg::ST_FREE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        s1_next.state = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twc_pkg::ST_FREE;
            wc_reg        <= '0;
            wrapped_reg   <= 1'b0;
            end_reg       <= '0;
            dec_cnt_reg   <= '0;
            wait_reg      <= '0;
            kept_any_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wc_reg       <= wc_next;
            wrapped_reg  <= wrapped_next;
            end_reg      <= end_next;
            dec_cnt_reg  <= dec_cnt_next;
            wait_reg     <= wait_next;
            kept_any_reg <= kept_any_next;
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        if (in_acc)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            out_state_reg <= s1_reg.state;
            out_rd_ok_reg <= s1_reg.rd_ok;
            out_data_reg  <= (s1_reg.rd_ok && !s1_reg.blank) ? rd_word : '0;
            out_err_reg   <= s1_reg.err;
        end
    end

    // channel banks
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_bank
        if (c < 4)
        begin : g_live
            assign bank_wdata[c] = fit[c][SAMPLE_WIDTH-1:0];
        end
        else
        begin : g_dead
            assign bank_wdata[c] = '0;
        end

        twc_ram #(
            .WIDTH (SAMPLE_WIDTH),
            .DEPTH (BUFFER_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (mem_we),
            .waddr (wc_reg),
            .wdata (bank_wdata[c]),
            .re    (mem_re),
            .raddr (rd_addr),
            .rdata (bank_rdata[c])
        );
    end

    always_comb
    begin
        logic signed [SAMPLE_WIDTH-1:0] w;
        bank_word = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (4'(c) == 4'(s1_reg.ch))
            begin
                bank_word = bank_rdata[c];
            end
        end
        w       = bank_word;
        rd_word = twc_pkg::DATA_W'(w);
    end

    assign result.valid         = out_valid_reg;
    assign result.capture_state = out_state_reg;
    assign result.read_valid    = out_rd_ok_reg;
    assign result.read_data     = out_data_reg;
    assign result.error         = out_err_reg;

endmodule

[src/twc_ram.sv]
module twc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/twc_checker.sv]
module twc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic [twc_pkg::ST_W-1:0]         capture_state,
    input logic                             read_valid,
    input logic signed [twc_pkg::DATA_W-1:0] read_data,
    input logic                             error
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable({capture_state, read_valid, read_data, error}))
        else $error("result changed while stalled");

    // data only comes back from a stopped engine without error
    a_read_stop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && read_valid |-> capture_state == twc_pkg::ST_STOP && !error)
        else $error("read data outside stopped state");

    a_err_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && error |-> capture_state != twc_pkg::ST_STOP && !read_valid)
        else $error("error reported while stopped");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !read_valid |-> read_data == '0)
        else $error("nonzero data without read_valid");

endmodule

bind triggered_wave_capture_core twc_checker u_twc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .capture_state (result.capture_state),
    .read_valid    (result.read_valid),
    .read_data     (result.read_data),
    .error         (result.error)
);
